[rtl/core/cpp_pkg.sv]
`timescale 1ns / 1ps
package cpp_pkg;

  localparam int RotW   = 18;
  localparam int PtW    = 32;
  localparam int PcW    = 52;   // 18x32 product plus three-term sum
  localparam int IntrW  = 24;
  localparam int NumW   = 80;   // 25-bit signed coefficient x 52 + sum growth
  localparam int MagW   = 79;
  localparam int QLimW  = 41;   // quotient bits kept before calling it big
  localparam int DivW   = 52;   // divisor magnitude bits

  // Register indexes
  localparam logic [2:0] RegRot0    = 3'd0;
  localparam logic [2:0] RegRot1    = 3'd1;
  localparam logic [2:0] RegRot2    = 3'd2;
  localparam logic [2:0] RegFocalX  = 3'd3;
  localparam logic [2:0] RegFocalY  = 3'd4;
  localparam logic [2:0] RegCenterX = 3'd5;
  localparam logic [2:0] RegCenterY = 3'd6;
  localparam logic [2:0] RegSkew    = 3'd7;

  typedef struct packed {
    logic signed [PtW-1:0] point_x;
    logic signed [PtW-1:0] point_y;
    logic signed [PtW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               depth_zero;
    logic               saturated;
  } pixel_t;

  // Front-to-back queue entry: numerators and depth.
  typedef struct packed {
    logic signed [NumW-1:0] num_u;
    logic signed [NumW-1:0] num_v;
    logic signed [PcW-1:0]  depth;
  } frac_t;

  typedef struct packed {
    logic [RotW*3-1:0] rot0;
    logic [RotW*3-1:0] rot1;
    logic [RotW*3-1:0] rot2;
    logic [IntrW-1:0]  fx;
    logic [IntrW-1:0]  fy;
    logic [IntrW-1:0]  cx;
    logic [IntrW-1:0]  cy;
    logic [IntrW-1:0]  sk;
  } cfg_t;

endpackage

[rtl/core/camera_point_projection.sv]
`timescale 1ns / 1ps
// Channel   | Ports                          | Handshake
// points in | point, push, full              | accept: push && !full
// pixels out| pixel, pop, empty              | accept: pop && !empty
// config    | cfg_we, cfg_index, cfg_data    | write when cfg_we
//
// One point per cycle sustained while neither side stalls. A point passes 5 front
// stages, the queue, an entry register and 40 divider stages (two quotient
// bits each, one in the last) before it shows on pixel.
// rst is synchronous and restores the identity rotation and default
// intrinsics. Either side may stall: the front-back queue and per-stage
// valids absorb backpressure without losing an item.
module camera_point_projection import cpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  point_t      point,
  output logic        empty,
  input  logic        pop,
  output pixel_t      pixel,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [53:0] cfg_data
);
  cfg_t  cfg;
  logic  f_valid, f_ready, q_valid, q_ready, in_ready, out_valid;
  frac_t f_item, q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot0 <= 54'd4503599627370496;
      cfg.rot1 <= 54'd17179869184;
      cfg.rot2 <= 54'd65536;
      cfg.fx   <= 24'd256000;
      cfg.fy   <= 24'd256000;
      cfg.cx   <= '0;
      cfg.cy   <= '0;
      cfg.sk   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRot0:    cfg.rot0 <= cfg_data;
        RegRot1:    cfg.rot1 <= cfg_data;
        RegRot2:    cfg.rot2 <= cfg_data;
        RegFocalX:  cfg.fx   <= cfg_data[23:0];
        RegFocalY:  cfg.fy   <= cfg_data[23:0];
        RegCenterX: cfg.cx   <= cfg_data[23:0];
        RegCenterY: cfg.cy   <= cfg_data[23:0];
        RegSkew:    cfg.sk   <= cfg_data[23:0];
        default:    ;
      endcase
    end
  end

  assign full = !in_ready;

  cpp_front u_front (
    .clk, .rst, .cfg,
    .in_valid(push), .in_item(point), .in_ready,
    .out_valid(f_valid), .out_item(f_item), .out_ready(f_ready)
  );

  cpp_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_item(f_item), .in_ready(f_ready),
    .out_valid(q_valid), .out_item(q_item), .out_ready(q_ready)
  );

  cpp_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_item(q_item), .in_ready(q_ready),
    .out_valid, .out_item(pixel), .out_ready(pop)
  );

  assign empty = !out_valid;

  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty) else $error("pending pixel vanished");
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(pixel)) else $error("pixel changed while held");
  assert property (@(posedge clk) disable iff (rst)
    (f_valid && !f_ready) |=> f_valid) else $error("front item dropped");
endmodule

[rtl/core/cpp_front.sv]
`timescale 1ns / 1ps
// Rotation and numerator formation, 5 stages, stallable.
module cpp_front import cpp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  input  point_t in_item,
  output logic   in_ready,
  output logic   out_valid,
  output frac_t  out_item,
  input  logic   out_ready
);
  logic [4:0] v;
  logic [4:0] adv;
  // stage 0: products
  logic signed [49:0] prod [3][3];
  // stage 1: camera point
  logic signed [PcW-1:0] pc0, pc1, pc2;
  // stage 2: intrinsic partial products, camera values split in two halves
  logic signed [51:0] plo [5];
  logic signed [50:0] phi [5];
  logic signed [PcW-1:0]  pc2b;
  // stage 3: full intrinsic products
  logic signed [NumW-1:0] mfx, msk, mcx, mfy, mcy;
  logic signed [PcW-1:0]  pc2c;
  // stage 4: sums
  frac_t res;
  // intrinsic coefficients as 25-bit signed
  logic signed [24:0] cfx, csk, ccx, cfy, ccy;

  function automatic logic signed [RotW-1:0] rot_at(input logic [RotW*3-1:0] row,
                                                    input int col);
    rot_at = row[RotW*(3-col)-1 -: RotW];
  endfunction

  // coefficient times low 26 bits of the camera value (unsigned part)
  function automatic logic signed [51:0] mul_lo(input logic signed [24:0] c,
                                                input logic signed [PcW-1:0] p);
    mul_lo = c * $signed({1'b0, p[25:0]});
  endfunction

  // coefficient times high 26 bits of the camera value (signed part)
  function automatic logic signed [50:0] mul_hi(input logic signed [24:0] c,
                                                input logic signed [PcW-1:0] p);
    mul_hi = c * $signed(p[PcW-1:26]);
  endfunction

  function automatic logic signed [NumW-1:0] join_parts(input logic signed [51:0] lo,
                                                        input logic signed [50:0] hi);
    join_parts = NumW'($signed({hi, 26'd0})) + NumW'(lo);
  endfunction

  assign cfx = $signed({1'b0, cfg.fx});
  assign csk = $signed({cfg.sk[IntrW-1], cfg.sk});
  assign ccx = $signed({1'b0, cfg.cx});
  assign cfy = $signed({1'b0, cfg.fy});
  assign ccy = $signed({1'b0, cfg.cy});

  assign adv[4] = !v[4] || out_ready;
  assign adv[3] = !v[3] || adv[4];
  assign adv[2] = !v[2] || adv[3];
  assign adv[1] = !v[1] || adv[2];
  assign adv[0] = !v[0] || adv[1];
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
      if (adv[4]) v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int j = 0; j < 3; j++) begin
        prod[0][j] <= rot_at(cfg.rot0, j) * in_item.point_x;
        prod[1][j] <= rot_at(cfg.rot1, j) * in_item.point_y;
        prod[2][j] <= rot_at(cfg.rot2, j) * in_item.point_z;
      end
    end
    if (adv[1]) begin
      pc0 <= PcW'(prod[0][0]) + PcW'(prod[1][0]) + PcW'(prod[2][0]);
      pc1 <= PcW'(prod[0][1]) + PcW'(prod[1][1]) + PcW'(prod[2][1]);
      pc2 <= PcW'(prod[0][2]) + PcW'(prod[1][2]) + PcW'(prod[2][2]);
    end
    if (adv[2]) begin
      plo[0] <= mul_lo(cfx, pc0);  phi[0] <= mul_hi(cfx, pc0);
      plo[1] <= mul_lo(csk, pc1);  phi[1] <= mul_hi(csk, pc1);
      plo[2] <= mul_lo(ccx, pc2);  phi[2] <= mul_hi(ccx, pc2);
      plo[3] <= mul_lo(cfy, pc1);  phi[3] <= mul_hi(cfy, pc1);
      plo[4] <= mul_lo(ccy, pc2);  phi[4] <= mul_hi(ccy, pc2);
      pc2b <= pc2;
    end
    if (adv[3]) begin
      mfx  <= join_parts(plo[0], phi[0]);
      msk  <= join_parts(plo[1], phi[1]);
      mcx  <= join_parts(plo[2], phi[2]);
      mfy  <= join_parts(plo[3], phi[3]);
      mcy  <= join_parts(plo[4], phi[4]);
      pc2c <= pc2b;
    end
    if (adv[4]) begin
      res.num_u <= mfx + msk + mcx;
      res.num_v <= mfy + mcy;
      res.depth <= pc2c;
    end
  end

  assign out_valid = v[4];
  assign out_item  = res;
endmodule

[rtl/core/cpp_queue.sv]
`timescale 1ns / 1ps
// Short register queue between front and back.
module cpp_queue import cpp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  frac_t in_item,
  output logic  in_ready,
  output logic  out_valid,
  output frac_t out_item,
  input  logic  out_ready
);
  frac_t      mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       wr, rd;

  assign in_ready  = cnt != 3'd4;
  assign out_valid = cnt != 3'd0;
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;
  assign out_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, wr} - {2'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_item;
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 3'd0) |-> !rd) else $error("read from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> (cnt == $past(cnt) + 3'd1)) else $error("count mismatch");
endmodule

[rtl/core/cpp_back.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, two quotient bits per stage (one in the last), then round/saturate.
module cpp_back import cpp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  frac_t  in_item,
  output logic   in_ready,
  output logic   out_valid,
  output pixel_t out_item,
  input  logic   out_ready
);
  localparam int Steps = MagW;           // one bit per step
  localparam int BPS   = 2;              // bits per stage
  localparam int Stg   = (Steps + BPS - 1) / BPS;
  localparam int RemW  = DivW + 1;

  typedef struct packed {
    logic [MagW-1:0] nu, nv;     // shifting numerators
    logic [RemW-1:0] ru, rv;
    logic [QLimW-1:0] qu, qv;
    logic            bu, bv;     // quotient exceeded limit
    logic [DivW-1:0] d;
    logic            negu, negv, dz;
  } dstate_t;

  dstate_t st [Stg+1];
  logic [Stg:0] v;
  logic [Stg:0] adv;
  dstate_t s0;
  logic    dneg;

  always_comb begin
    dneg     = in_item.depth[PcW-1];
    s0       = '0;
    s0.d     = DivW'(dneg ? -in_item.depth : in_item.depth);
    s0.nu    = MagW'(in_item.num_u[NumW-1] ? -in_item.num_u : in_item.num_u);
    s0.nv    = MagW'(in_item.num_v[NumW-1] ? -in_item.num_v : in_item.num_v);
    s0.negu  = in_item.num_u[NumW-1] ^ dneg;
    s0.negv  = in_item.num_v[NumW-1] ^ dneg;
    s0.dz    = in_item.depth == '0;
  end

  function automatic void step(input logic [DivW-1:0] d, inout logic [MagW-1:0] n,
                               inout logic [RemW-1:0] r, inout logic [QLimW-1:0] q,
                               inout logic b);
    logic [RemW:0] t;
    logic          qb;
    t  = {r, n[MagW-1]};
    n  = n << 1;
    qb = t >= {1'b0, d};
    if (qb) t = t - {1'b0, d};
    r  = t[RemW-1:0];
    if (!b) begin
      q = {q[QLimW-2:0], qb};
      if (q[QLimW-1]) b = 1'b1;
    end
  endfunction

  genvar g;
  for (g = 0; g <= Stg; g++) begin : g_adv
    if (g == Stg) begin : g_last
      assign adv[g] = !v[g] || out_ready;
    end else begin : g_mid
      assign adv[g] = !v[g] || adv[g+1];
    end
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k <= Stg; k++) if (adv[k]) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) st[0] <= s0;
    for (int k = 1; k <= Stg; k++) begin
      if (adv[k]) begin
        dstate_t x;
        x = st[k-1];
        for (int b = 0; b < BPS; b++) begin
          if ((k-1)*BPS + b < Steps) begin
            step(x.d, x.nu, x.ru, x.qu, x.bu);
            step(x.d, x.nv, x.rv, x.qv, x.bv);
          end
        end
        st[k] <= x;
      end
    end
  end

  // Round, sign and clamp one coordinate.
  function automatic logic [32:0] finish(input logic [QLimW-1:0] q, input logic big,
                                         input logic [RemW-1:0] r,
                                         input logic [DivW-1:0] d, input logic neg);
    logic [QLimW:0] qr;
    logic [31:0]    o;
    logic           s;
    qr = {1'b0, q} + {{QLimW{1'b0}}, ({r, 1'b0} >= {1'b0, d})};
    s  = 1'b0;
    if (neg) begin
      if (big || qr > (QLimW+1)'(64'h8000_0000)) begin
        s = 1'b1; o = 32'h8000_0000;
      end else o = 32'(-qr);
    end else begin
      if (big || qr > (QLimW+1)'(64'h7FFF_FFFF)) begin
        s = 1'b1; o = 32'h7FFF_FFFF;
      end else o = qr[31:0];
    end
    finish = {s, o};
  endfunction

  logic [32:0] fu, fv;
  dstate_t     sf;
  assign sf = st[Stg];
  assign fu = finish(sf.qu, sf.bu, sf.ru, sf.d, sf.negu);
  assign fv = finish(sf.qv, sf.bv, sf.rv, sf.d, sf.negv);

  always_comb begin
    if (sf.dz) begin
      out_item = '0;
      out_item.depth_zero = 1'b1;
    end else begin
      out_item.pixel_u    = fu[31:0];
      out_item.pixel_v    = fv[31:0];
      out_item.depth_zero = 1'b0;
      out_item.saturated  = fu[32] | fv[32];
    end
  end
  assign out_valid = v[Stg];

  assert property (@(posedge clk) disable iff (rst)
    (v[Stg] && !out_ready) |=> v[Stg]) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.depth_zero) |-> !out_item.saturated)
    else $error("zero depth flagged saturated");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0]) else $error("item lost on entry");
endmodule

[dv/tb_camera_point_projection.sv]
`timescale 1ns / 1ps
module tb_camera_point_projection;
  import cpp_pkg::*;

  localparam int DrainCycles = 120;     // 5 front + queue + 41 divider registers, with margin
  localparam int WatchdogLimit = 20000; // cycles without any accepted item

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  point_t      point;
  logic        empty;
  logic        pop;
  pixel_t      pixel;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [53:0] cfg_data;

  camera_point_projection u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .point(point),
    .empty(empty), .pop(pop), .pixel(pixel),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Shadow copy of the configuration registers.
  logic [53:0] rot_row [3];
  logic [23:0] fx_r, fy_r, cx_r, cy_r;
  logic signed [23:0] sk_r;

  point_t pending_points[$];
  pixel_t expected_pixels[$];
  int     errors;
  int     idle_cycles;
  bit     hold_pop;      // long receiver hold-off request
  bit     sender_pause;  // driver stops offering while set
  bit     in_taken;      // input item accepted at the last rising edge

  task automatic report(input string what, input pixel_t got, input pixel_t exp);
    errors++;
    $display("mismatch %s: got u=%0d v=%0d dz=%0b sat=%0b exp u=%0d v=%0d dz=%0b sat=%0b",
             what, got.pixel_u, got.pixel_v, got.depth_zero, got.saturated,
             exp.pixel_u, exp.pixel_v, exp.depth_zero, exp.saturated);
  endtask

  // Round to nearest (ties away from zero) and clamp to 32 bits.
  function automatic logic signed [31:0] round_clamp(input logic signed [127:0] num,
                                                     input logic signed [127:0] den,
                                                     inout bit sat);
    logic [127:0] n, d, q, r;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    if (2 * r >= d) q++;
    if (neg) begin
      if (q > 128'd2147483648) begin
        sat = 1; return 32'sh80000000;
      end
      return -$signed(q[31:0]);
    end
    if (q > 128'd2147483647) begin
      sat = 1; return 32'sh7fffffff;
    end
    return q[31:0];
  endfunction

  function automatic pixel_t project_point(input point_t p);
    logic signed [127:0] pw [3];
    logic signed [127:0] cam [3];
    logic signed [127:0] nu, nv;
    logic signed [17:0] rc;
    pixel_t res;
    bit sat;
    pw[0] = p.point_x; pw[1] = p.point_y; pw[2] = p.point_z;
    // camera point = R^T * inertial point
    for (int j = 0; j < 3; j++) begin
      cam[j] = 0;
      for (int i = 0; i < 3; i++) begin
        rc = rot_row[i][53 - 18*j -: 18];
        cam[j] += 128'(rc) * pw[i];
      end
    end
    res = '0;
    sat = 0;
    if (cam[2] == 0) begin
      res.depth_zero = 1'b1;
      return res;
    end
    nu = $signed({104'd0, fx_r}) * cam[0] + 128'(sk_r) * cam[1]
       + $signed({104'd0, cx_r}) * cam[2];
    nv = $signed({104'd0, fy_r}) * cam[1] + $signed({104'd0, cy_r}) * cam[2];
    res.pixel_u = round_clamp(nu, cam[2], sat);
    res.pixel_v = round_clamp(nv, cam[2], sat);
    res.saturated = sat;
    return res;
  endfunction

  // Driver: inputs change on the falling edge.
  int gap;
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      gap  <= 0;
    end else if (push && !in_taken) begin
      // keep offering the same item
    end else begin
      if (push) begin
        expected_pixels.push_back(project_point(point));
        void'(pending_points.pop_front());
      end
      if (gap > 0 || sender_pause || pending_points.size() == 0) begin
        push <= 1'b0;
        if (gap > 0) gap <= gap - 1;
      end else begin
        push  <= 1'b1;
        point <= pending_points[0];
        gap   <= ($urandom_range(0, 3) == 0) ?
                 (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
                 : 0;
      end
    end
  end

  // Receiver: pop with random gaps, or held off entirely on request.
  int pop_gap;
  always @(negedge clk) begin
    if (rst || hold_pop) begin
      pop <= 1'b0;
      pop_gap <= 0;
    end else if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        pop_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  // Monitor: results sampled on the rising edge.
  pixel_t exp_pix;
  always @(posedge clk) begin
    in_taken = !rst && push && !full;
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected item", pixel, '0);
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (pixel.pixel_u !== exp_pix.pixel_u) report("pixel_u", pixel, exp_pix);
          if (pixel.pixel_v !== exp_pix.pixel_v) report("pixel_v", pixel, exp_pix);
          if (pixel.depth_zero !== exp_pix.depth_zero) report("depth_zero", pixel, exp_pix);
          if (pixel.saturated !== exp_pix.saturated) report("saturated", pixel, exp_pix);
        end
      end
    end
  end

  // Watchdog: nothing accepted for too long means a hang.
  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Register write, only while the block is idle; updates the shadow copy.
  task automatic write_reg(input logic [2:0] idx, input logic [53:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      RegRot0:    rot_row[0] = val;
      RegRot1:    rot_row[1] = val;
      RegRot2:    rot_row[2] = val;
      RegFocalX:  fx_r = val[23:0];
      RegFocalY:  fy_r = val[23:0];
      RegCenterX: cx_r = val[23:0];
      RegCenterY: cy_r = val[23:0];
      RegSkew:    sk_r = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0 || push || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic signed [17:0] rand_rot_entry();
    case ($urandom_range(0, 5))
      0: return 18'sh20000;
      1: return 18'sh1ffff;
      2: return 18'sh10000;
      3: return -18'sh10000;
      4: return 18'sd0;
      default: return 18'($urandom());
    endcase
  endfunction

  function automatic logic [23:0] rand_intr();
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return 24'hffffff;
      2: return 24'($urandom_range(0, 1000000));
      default: return 24'($urandom());
    endcase
  endfunction

  // Three in eight coordinates are of moderate size; the rest are full-range or extreme.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 0;
      3, 4: return $urandom();
      default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  task automatic add_point(input logic signed [31:0] x, input logic signed [31:0] y,
                           input logic signed [31:0] z);
    point_t p;
    p.point_x = x; p.point_y = y; p.point_z = z;
    pending_points.push_back(p);
  endtask

  task automatic randomize_config();
    logic [53:0] rowv;
    for (int i = 0; i < 3; i++) begin
      rowv = {rand_rot_entry(), rand_rot_entry(), rand_rot_entry()};
      write_reg(3'(i), rowv);
    end
    write_reg(RegFocalX, {30'd0, rand_intr()});
    write_reg(RegFocalY, {30'd0, rand_intr()});
    write_reg(RegCenterX, {30'd0, rand_intr()});
    write_reg(RegCenterY, {30'd0, rand_intr()});
    write_reg(RegSkew, {30'd0, rand_intr()});
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_pop = 0;
    sender_pause = 0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    point = '0;
    cfg_we = 1'b0;
    cfg_index = RegRot0;
    cfg_data = '0;
    rot_row[0] = 54'd4503599627370496;
    rot_row[1] = 54'd17179869184;
    rot_row[2] = 54'd65536;
    fx_r = 24'd256000; fy_r = 24'd256000;
    cx_r = '0; cy_r = '0; sk_r = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, reset configuration: zero depth, behind camera, extremes.
    add_point(0, 0, 0);
    add_point(32'sh10000, 32'sh10000, 0);
    add_point(32'sh10000, -32'sh10000, 32'sh10000);
    add_point(32'sh10000, 32'sh10000, -32'sh10000);
    add_point(32'sh7fffffff, 32'sh80000000, 1);
    add_point(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    add_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_point(1, 1, 32'sh7fffffff);
    add_point(-1, -1, 2);
    add_point(1, 3, 2);
    add_point(32'shffffffff, 32'shffffffff, 32'shffffffff);
    wait_drained();

    // Extreme configuration: largest positive, all-ones and most-negative values.
    write_reg(RegRot0, {18'sh20000, 18'sh1ffff, 18'sh20000});
    write_reg(RegRot1, {18'sh1ffff, 18'sh20000, 18'sh1ffff});
    write_reg(RegRot2, {18'sh20000, 18'sh20000, 18'sh1ffff});
    write_reg(RegFocalX, 54'hffffff);
    write_reg(RegFocalY, 54'hffffff);
    write_reg(RegCenterX, 54'hffffff);
    write_reg(RegCenterY, 54'hffffff);
    write_reg(RegSkew, 54'h800000);
    add_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    add_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    add_point(1, -1, 1);
    add_point(0, 0, 0);
    add_point(32'sh12345678, -32'sh789abc, 32'sh1000);
    wait_drained();

    // Random phases with new settings between them.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase != 0) randomize_config();
      for (int k = 0; k < 235; k++) add_point(rand_coord(), rand_coord(), rand_coord());
      if (phase == 2) begin
        // Receiver holds off while the sender keeps offering: fill and stall.
        hold_pop = 1;
        repeat (400) @(posedge clk);
        hold_pop = 0;
      end
      if (phase == 4) begin
        // Sender pauses until every expected item has drained.
        while (pending_points.size() > 120) @(posedge clk);
        sender_pause = 1;
        while (push || expected_pixels.size() != 0) @(posedge clk);
        sender_pause = 0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
